FILE: hdl/upd_pkg.sv
// Shared types, constants and helpers for the URL percent decoder.
package upd_pkg;

   // Defaults and sizes
   localparam int unsigned LENGTH_WIDTH_DEFAULT = 16;
   localparam int unsigned REC_DEPTH            = 4;
   localparam int unsigned RSP_DEPTH            = 4;
   localparam logic [15:0] MAX_LEN_RESET        = 16'hFFFF;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_LEN    = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNT_ONLY = 1'b1;

   // Character codes
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_UA      = 8'h41;
   localparam logic [7:0] CH_UF      = 8'h46;
   localparam logic [7:0] CH_LA      = 8'h61;
   localparam logic [7:0] CH_LF      = 8'h66;
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [3:0] HEX_TEN    = 4'd10;

   // Input beat
   typedef struct packed {
      logic [7:0] in_byte;
      logic       close;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_summary;
      logic [15:0] total_length;
      logic        failed;
      logic        last;
   } rsp_type;

   // Work record from front to back: up to three candidate bytes, then an optional summary
   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      count;
      logic            summary;
   } rec_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   // Hex digit decode, either case
   function automatic hex_type hex_decode(input logic [7:0] ch);
      hex_type h;
      h = '0;
      if (ch >= CH_0 && ch <= CH_9) begin
         h.ok  = 1'b1;
         h.val = 4'(ch - CH_0);
      end else if (ch >= CH_UA && ch <= CH_UF) begin
         h.ok  = 1'b1;
         h.val = 4'(ch - CH_UA) + HEX_TEN;
      end else if (ch >= CH_LA && ch <= CH_LF) begin
         h.ok  = 1'b1;
         h.val = 4'(ch - CH_LA) + HEX_TEN;
      end
      return h;
   endfunction

endpackage

FILE: hdl/upd_fifo.sv
// Small register-based first-in first-out queue.
module upd_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CW'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/upd_front.sv
// Front end: escape parser that makes a work record of each beat with output.
module upd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  upd_pkg::req_type req_data,
   output logic             rec_push,
   output upd_pkg::rec_type rec_data,
   input  logic             rec_full
);

   typedef enum logic [1:0] {
      PH_PLAIN,
      PH_PCT,
      PH_DIGIT
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [3:0]       digit_ff, digit_in;
   logic             ended_ff, ended_in;

   logic             accept;
   upd_pkg::hex_type hex;
   logic [7:0]       digit_byte;
   logic [1:0]       fl_n;
   logic [7:0]       fl_b0, fl_b1;
   logic             use_flush;
   logic             add_byte;
   logic [7:0]       app_byte;
   logic             triple_zero;
   upd_pkg::rec_type rec;

   assign req_full = rec_full;
   assign accept   = req_push && !rec_full;
   assign hex      = upd_pkg::hex_decode(req_data.in_byte);

   // Pending escape flush; close leaves a lone digit unshifted
   always_comb begin
      digit_byte = req_data.close ? {4'h0, digit_ff} : {digit_ff, 4'h0};
      fl_n  = 2'd0;
      fl_b0 = upd_pkg::CH_PERCENT;
      fl_b1 = upd_pkg::CH_0;
      unique case (phase_ff)
         PH_PCT: begin
            fl_n = 2'd1;
         end
         PH_DIGIT: begin
            if (digit_ff != 4'h0) begin
               fl_n  = 2'd1;
               fl_b0 = digit_byte;
            end else begin
               fl_n = 2'd2;
            end
         end
         default: begin
            fl_n = 2'd0;
         end
      endcase
   end

   // Classify the beat and step the parse state
   always_comb begin
      phase_in    = phase_ff;
      digit_in    = digit_ff;
      ended_in    = ended_ff;
      use_flush   = 1'b0;
      add_byte    = 1'b0;
      app_byte    = req_data.in_byte;
      triple_zero = 1'b0;
      rec         = '0;
      if (req_data.close) begin
         use_flush   = !ended_ff;
         rec.summary = 1'b1;
         phase_in    = PH_PLAIN;
         digit_in    = 4'h0;
         ended_in    = 1'b0;
      end else if (!ended_ff) begin
         if (req_data.in_byte == upd_pkg::CH_NUL) begin
            use_flush = 1'b1;
            ended_in  = 1'b1;
            phase_in  = PH_PLAIN;
         end else begin
            unique case (phase_ff)
               PH_PCT, PH_DIGIT: begin
                  if (hex.ok && phase_ff == PH_PCT) begin
                     digit_in = hex.val;
                     phase_in = PH_DIGIT;
                  end else if (hex.ok) begin
                     phase_in = PH_PLAIN;
                     app_byte = {digit_ff, hex.val};
                     if (app_byte != upd_pkg::CH_NUL) begin
                        add_byte = 1'b1;
                     end else begin
                        triple_zero = 1'b1;
                     end
                  end else begin
                     // non-hex ends the escape; byte re-handled as plain text
                     use_flush = 1'b1;
                     if (req_data.in_byte == upd_pkg::CH_PERCENT) begin
                        phase_in = PH_PCT;
                     end else begin
                        phase_in = PH_PLAIN;
                        add_byte = 1'b1;
                     end
                  end
               end
               default: begin
                  if (req_data.in_byte == upd_pkg::CH_PERCENT) begin
                     phase_in = PH_PCT;
                  end else begin
                     add_byte = 1'b1;
                  end
               end
            endcase
         end
      end

      // Assemble candidate list
      if (triple_zero) begin
         rec.data[0] = upd_pkg::CH_PERCENT;
         rec.data[1] = upd_pkg::CH_0;
         rec.data[2] = upd_pkg::CH_0;
         rec.count   = 2'd3;
      end else begin
         if (use_flush) begin
            rec.data[0] = fl_b0;
            rec.data[1] = fl_b1;
            rec.count   = fl_n;
         end
         if (add_byte) begin
            unique case (rec.count)
               2'd0:    rec.data[0] = app_byte;
               2'd1:    rec.data[1] = app_byte;
               default: rec.data[2] = app_byte;
            endcase
            rec.count = rec.count + 2'd1;
         end
      end
   end

   assign rec_push = accept && (rec.count != 2'd0 || rec.summary);
   assign rec_data = rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PLAIN;
         digit_ff <= 4'h0;
         ended_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         digit_ff <= digit_in;
         ended_ff <= ended_in;
      end
   end

endmodule

FILE: hdl/upd_back.sv
// Back end: output counting, limit check and result beat generation.
module upd_back #(
   parameter int unsigned LENGTH_WIDTH = upd_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  upd_pkg::rec_type rec_data,
   input  logic             rec_empty,
   output logic             rec_pop,
   input  logic             out_full,
   output logic             out_push,
   output upd_pkg::rsp_type out_data,
   input  logic [15:0]      max_len,
   input  logic             count_only
);

   localparam int unsigned EW = ((LENGTH_WIDTH > 16) ? LENGTH_WIDTH : 16) + 2;

   logic [1:0]              step_ff, step_in;
   logic [LENGTH_WIDTH-1:0] count_ff, count_in;
   logic                    ovf_ff, ovf_in;

   logic                    go;
   logic                    is_emit;
   logic                    final_step;
   logic                    final_cand;
   logic                    next_ok;
   logic [7:0]              cur_byte;
   logic [EW-1:0]           cnt_e, lim_e, cmax_e;

   assign go         = !rec_empty && !out_full;
   assign is_emit    = step_ff < rec_data.count;
   assign final_cand = (step_ff == rec_data.count - 2'd1);
   assign final_step = rec_data.summary ? (step_ff == rec_data.count) : final_cand;

   assign cnt_e  = EW'(count_ff);
   assign lim_e  = EW'(max_len);
   assign cmax_e = EW'({LENGTH_WIDTH{1'b1}});
   // whether the following byte of this string could still be written
   assign next_ok = (cnt_e + EW'(2) <= lim_e) && (cnt_e + EW'(2) <= cmax_e);

   // Current candidate byte
   always_comb begin
      unique case (step_ff)
         2'd0:    cur_byte = rec_data.data[0];
         2'd1:    cur_byte = rec_data.data[1];
         default: cur_byte = rec_data.data[2];
      endcase
   end

   // One emit or summary slot per cycle while go is high
   always_comb begin
      step_in  = step_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      rec_pop  = 1'b0;
      out_push = 1'b0;
      out_data = '0;
      if (go) begin
         rec_pop = final_step;
         step_in = final_step ? 2'd0 : step_ff + 2'd1;
         if (is_emit) begin
            priority if (ovf_ff && !count_only) begin
               ovf_in = ovf_ff;
            end else if (&count_ff) begin
               ovf_in = 1'b1;
            end else begin
               count_in = count_ff + LENGTH_WIDTH'(1);
               if (!count_only) begin
                  if (cnt_e + EW'(1) > lim_e) begin
                     ovf_in = 1'b1;
                  end else begin
                     out_push          = 1'b1;
                     out_data.out_byte = cur_byte;
                     // a following summary always carries last
                     out_data.last     = !rec_data.summary && (final_cand || !next_ok);
                  end
               end
            end
         end else begin
            out_push              = 1'b1;
            out_data.is_summary   = 1'b1;
            out_data.total_length = (cnt_e > EW'(16'hFFFF)) ? 16'hFFFF : cnt_e[15:0];
            out_data.failed       = ovf_ff;
            out_data.last         = 1'b1;
            count_in              = '0;
            ovf_in                = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 2'd0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         step_ff  <= step_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

`ifndef SYNTHESIS
   // count-only mode writes no data beats
   a_count_only_quiet: assert property (@(posedge clock) disable iff (reset)
      (out_push && count_only) |-> out_data.is_summary)
      else $error("data beat written in count-only mode");

   // a summary always closes the results of its beat
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (out_push && out_data.is_summary) |-> out_data.last)
      else $error("summary beat without last");

   // after a summary the counters start from zero
   a_summary_clears: assert property (@(posedge clock) disable iff (reset)
      (go && !is_emit) |=> (count_ff == '0 && !ovf_ff))
      else $error("counters not cleared after summary");

   // a failed string writes no more data in write mode
   a_fail_stops: assert property (@(posedge clock) disable iff (reset)
      (ovf_ff && !count_only && out_push) |-> out_data.is_summary)
      else $error("data beat after limit exceeded");
`endif

endmodule

FILE: hdl/url_percent_decoder.sv
// Top level of the streaming URL percent decoder.
//
//   channel  direction  handshake           payload
//   req      in         req_push/req_full   req_data   (in_byte, close)
//   rsp      out        rsp_empty/rsp_pop   rsp_data   (out_byte, is_summary,
//                                                       total_length, failed, last)
//   csr      in         csr_valid/csr_ready csr_index, csr_wdata
//
// One input beat per cycle while the record queue is not full. The back end handles
// each candidate byte and each summary in turn, whether or not the byte is written out.
// A result reaches the result port through the record queue and then the result queue.
// A 4-entry record queue parts parser and counter; req_full follows it.
// A 4-entry result queue parts counter and result port; when full it stalls the back end.
// Reset clears queues, parse and count state, loads limit 65535 and write mode.
// csr_ready is always high.
module url_percent_decoder #(
   parameter int unsigned LENGTH_WIDTH = upd_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  upd_pkg::req_type                      req_data,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output upd_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [upd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [15:0]                           csr_wdata
);

   localparam int unsigned REC_W = $bits(upd_pkg::rec_type);
   localparam int unsigned RSP_W = $bits(upd_pkg::rsp_type);

   logic [15:0]      max_len_ff;
   logic             count_only_ff;

   logic             rec_push, rec_full, rec_pop, rec_empty;
   upd_pkg::rec_type rec_in, rec_out;
   logic             out_push, out_full;
   upd_pkg::rsp_type out_in;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff    <= upd_pkg::MAX_LEN_RESET;
         count_only_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            upd_pkg::CSR_MAX_LEN:    max_len_ff    <= csr_wdata;
            upd_pkg::CSR_COUNT_ONLY: count_only_ff <= csr_wdata[0];
            default:                 max_len_ff    <= max_len_ff;
         endcase
      end
   end

   upd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .rec_push (rec_push),
      .rec_data (rec_in),
      .rec_full (rec_full)
   );

   upd_fifo #(
      .WIDTH (REC_W),
      .DEPTH (upd_pkg::REC_DEPTH)
   ) u_rec_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (rec_in),
      .full      (rec_full),
      .pop       (rec_pop),
      .pop_data  (rec_out),
      .empty     (rec_empty)
   );

   upd_back #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .rec_data   (rec_out),
      .rec_empty  (rec_empty),
      .rec_pop    (rec_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_data   (out_in),
      .max_len    (max_len_ff),
      .count_only (count_only_ff)
   );

   upd_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (upd_pkg::RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_in),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule
